### rtl/lpft_pkg.sv
package lpft_pkg;

    localparam int MaxFrames  = 128;
    localparam int NumWindows = 5;
    localparam int AgeBits    = 16;
    localparam int IdxBits    = $clog2(MaxFrames);
    localparam int CntBits    = $clog2(MaxFrames + 1);
    localparam int WinBits    = $clog2(NumWindows + 1);

    // frame row is cut by a register after every SegCells cells
    localparam int SegCells     = 8;
    localparam int NumSegs      = MaxFrames / SegCells;
    localparam int SearchCycles = NumSegs + 1;
    localparam int SrchBits     = $clog2(SearchCycles);

    localparam logic [7:0]  FrameCountReset = 8'd128;
    localparam logic [15:0] WindowLenReset  = 16'd2000;

    // configuration register indexes
    localparam logic RegFrameCount = 1'b0;
    localparam logic RegWindowLen  = 1'b1;

    typedef logic [AgeBits-1:0] age_t;

    // per-frame command, same for every cell in a cycle
    typedef struct packed {
        logic        update;    // commit this reference
        logic        write_en;  // write page into target frame
        logic [IdxBits-1:0] target;
        logic [15:0] page;
        logic [CntBits-1:0] active;
    } cell_cmd_t;

    // result of one cell's compare, handed along the chain
    typedef struct packed {
        logic               hit;
        logic [IdxBits-1:0] hit_idx;
        age_t               best_age;
        logic [IdxBits-1:0] best_idx;
    } chain_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT,
        ST_OUT
    } state_t;

endpackage

### rtl/lpft_cell.sv
module lpft_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lpft_pkg::IdxBits-1:0] idx,
    input  lpft_pkg::cell_cmd_t          cmd,
    input  logic [15:0]                  lookup,
    input  lpft_pkg::chain_t             chain_in,
    output lpft_pkg::chain_t             chain_out,
    output logic [15:0]                  page_out
);

    logic [15:0]      page_reg;
    lpft_pkg::age_t   age_reg;
    logic             in_use;

    assign in_use   = {1'b0, idx} < cmd.active;
    assign page_out = page_reg;

    // page store, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.update && cmd.write_en && cmd.target == idx)
        begin
            page_reg <= cmd.page;
        end
    end

    // age: clear on target, else saturating increment when active
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (cmd.target == idx)
                age_reg <= '0;
            else if (in_use && age_reg != '1)
                age_reg <= age_reg + 1'b1;
        end
    end

    // first match wins; strictly older wins the eviction scan
    always_comb
    begin
        chain_out = chain_in;
        if (in_use)
        begin
            if (!chain_in.hit && page_reg == lookup)
            begin
                chain_out.hit     = 1'b1;
                chain_out.hit_idx = idx;
            end
            if (idx == '0 || age_reg > chain_in.best_age)
            begin
                chain_out.best_age = age_reg;
                chain_out.best_idx = idx;
            end
        end
    end

endmodule

### rtl/lru_page_frame_tracker.sv
// LRU page frame tracker: a row of frame cells, registered every SegCells cells.
// Each reference stays in the search state while the compare and age scan ripple
// through 16 segments, then passes through a commit state and an output state.
// The next input beat is taken only after the result beat has been taken, so
// output stalls add directly.
// Reset clears ages, counts and windows; page storage needs no reset.
module lru_page_frame_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] page_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // hit, frame_index[7], evicted, evicted_page[16],
                                   // window_number[3], window_faults[16],
                                   // total_faults[32], zero pad[4]
    output logic        m_tuser    // unused zero
);

    localparam int N  = lpft_pkg::MaxFrames;
    localparam int IB = lpft_pkg::IdxBits;
    localparam int CB = lpft_pkg::CntBits;
    localparam int WB = lpft_pkg::WinBits;
    localparam int SG = lpft_pkg::SegCells;
    localparam int NS = lpft_pkg::NumSegs;
    localparam int SB = lpft_pkg::SrchBits;

    lpft_pkg::state_t state_reg, state_next;
    logic [7:0]  fc_reg;
    logic [15:0] wl_reg;
    logic [15:0] page_reg;
    logic [CB-1:0] filled_reg;
    logic [15:0] pos_reg;
    logic [WB-1:0] win_reg;
    logic [15:0] wfault_reg [lpft_pkg::NumWindows];
    logic [31:0] total_reg;
    logic        hit_reg, evict_reg;
    logic [IB-1:0] slot_reg;
    logic [15:0] oldpg_reg;
    logic [79:0] out_reg;
    logic [SB-1:0] srch_reg;

    lpft_pkg::chain_t    chain [N+1];
    lpft_pkg::chain_t    cell_out [N];
    lpft_pkg::chain_t    seg_reg [NS];
    lpft_pkg::cell_cmd_t cmd;
    logic [15:0]         pages [N];

    logic [CB-1:0] n_use, active;
    logic          full;

    // effective frame count and active range
    always_comb
    begin
        if (fc_reg == 8'd0)
            n_use = CB'(1);
        else if (fc_reg > 8'(N))
            n_use = CB'(N);
        else
            n_use = CB'(fc_reg);
        active = (filled_reg < n_use) ? filled_reg : n_use;
        full   = !(filled_reg < n_use);
    end

    assign chain[0] = '0;

    // frame row; the chain is registered at the end of each segment
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        lpft_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IB'(i)),
            .cmd       (cmd),
            .lookup    (page_reg),
            .chain_in  (chain[i]),
            .chain_out (cell_out[i]),
            .page_out  (pages[i])
        );
        if ((i % SG) == SG - 1)
        begin : g_seg_end
            assign chain[i+1] = seg_reg[i / SG];
        end
        else
        begin : g_seg_mid
            assign chain[i+1] = cell_out[i];
        end
    end

    // segment boundary registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                seg_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
                seg_reg[k] <= cell_out[k*SG + SG - 1];
        end
    end

    // search cycle count, restarts for every reference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            srch_reg <= '0;
        else if (state_reg == lpft_pkg::ST_SEARCH)
            srch_reg <= srch_reg + 1'b1;
        else
            srch_reg <= '0;
    end

    // commit command to the cells
    always_comb
    begin
        cmd.update   = (state_reg == lpft_pkg::ST_COMMIT);
        cmd.write_en = !hit_reg;
        cmd.target   = slot_reg;
        cmd.page     = page_reg;
        cmd.active   = (cmd.update && !hit_reg && !full) ? filled_reg + 1'b1 : active;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpft_pkg::ST_IDLE:   if (s_tvalid) state_next = lpft_pkg::ST_SEARCH;
            lpft_pkg::ST_SEARCH:
                if (srch_reg == SB'(lpft_pkg::SearchCycles - 1))
                    state_next = lpft_pkg::ST_COMMIT;
            lpft_pkg::ST_COMMIT: state_next = lpft_pkg::ST_OUT;
            lpft_pkg::ST_OUT:    if (m_tready) state_next = lpft_pkg::ST_IDLE;
            default:             state_next = lpft_pkg::ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == lpft_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == lpft_pkg::ST_OUT);
    assign m_tdata  = out_reg;
    assign m_tuser  = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lpft_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= lpft_pkg::FrameCountReset;
            wl_reg <= lpft_pkg::WindowLenReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpft_pkg::RegFrameCount: fc_reg <= cfg_data[7:0];
                default:                 wl_reg <= cfg_data;
            endcase
        end
    end

    // datapath payload; the last search cycle holds the settled chain
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            page_reg <= s_tdata;
        if (state_reg == lpft_pkg::ST_SEARCH)
        begin
            hit_reg   <= chain[N].hit;
            evict_reg <= !chain[N].hit && full;
            if (chain[N].hit)
                slot_reg <= chain[N].hit_idx;
            else if (!full)
                slot_reg <= IB'(filled_reg);
            else
                slot_reg <= chain[N].best_idx;
            oldpg_reg <= (!chain[N].hit && full) ? pages[chain[N].best_idx] : 16'd0;
        end
    end

    // counters and result beat
    logic [15:0] wf_new;
    logic [31:0] tot_new;
    logic [15:0] len;
    logic        in_win;

    always_comb
    begin
        in_win  = win_reg < WB'(lpft_pkg::NumWindows);
        wf_new  = 16'd0;
        if (in_win)
        begin
            wf_new = wfault_reg[win_reg[WB-1:0]];
            if (!hit_reg && wf_new != 16'hFFFF)
                wf_new = wf_new + 1'b1;
        end
        tot_new = total_reg;
        if (!hit_reg && tot_new != 32'hFFFF_FFFF)
            tot_new = tot_new + 1'b1;
        len = (wl_reg == 16'd0) ? 16'd1 : wl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            pos_reg    <= '0;
            win_reg    <= '0;
            total_reg  <= '0;
            for (int w = 0; w < lpft_pkg::NumWindows; w++)
                wfault_reg[w] <= '0;
        end
        else if (state_reg == lpft_pkg::ST_COMMIT)
        begin
            if (!hit_reg && !full)
                filled_reg <= filled_reg + 1'b1;
            total_reg <= tot_new;
            if (in_win)
            begin
                wfault_reg[win_reg] <= wf_new;
                if (pos_reg + 1'b1 >= len)
                begin
                    pos_reg <= '0;
                    win_reg <= win_reg + 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lpft_pkg::ST_COMMIT)
            out_reg <= {4'd0, tot_new, wf_new, win_reg, oldpg_reg, evict_reg,
                        7'(slot_reg), hit_reg};
    end

`ifndef SYNTHESIS
    a_out_only_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == lpft_pkg::ST_COMMIT)
        else $error("output without commit");
    a_no_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg[0] && out_reg[8]))
        else $error("hit and eviction together");
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CB'(N))
        else $error("filled count overflow");
`endif

endmodule

### tb/lru_page_frame_tracker_tb.sv
`timescale 1ns / 1ps

module lru_page_frame_tracker_tb;

    typedef struct packed {
        bit          hit;
        bit [6:0]    frame_index;
        bit          evicted;
        bit [15:0]   evicted_page;
        bit [2:0]    window_number;
        bit [15:0]   window_faults;
        bit [31:0]   total_faults;
    } lookup_result_t;

    // LRU table predictor plus queue of expected lookups
    class lru_scoreboard;
        bit [15:0] page_tbl [lpft_pkg::MaxFrames];
        bit [lpft_pkg::AgeBits-1:0] age_tbl [lpft_pkg::MaxFrames];
        int unsigned filled;
        int unsigned win_pos;
        int unsigned cur_win;
        bit [15:0] win_faults [lpft_pkg::NumWindows];
        bit [31:0] fault_sum;
        bit [7:0]  frames_reg;
        bit [15:0] win_len_reg;
        lookup_result_t pending [$];
        int unsigned errors;

        function new();
            frames_reg  = lpft_pkg::FrameCountReset;
            win_len_reg = lpft_pkg::WindowLenReset;
            filled = 0; win_pos = 0; cur_win = 0; fault_sum = 0; errors = 0;
            foreach (age_tbl[i]) age_tbl[i] = '0;
            foreach (win_faults[i]) win_faults[i] = '0;
        endfunction

        function void set_reg(logic idx, bit [15:0] val);
            if (idx == lpft_pkg::RegFrameCount) frames_reg = val[7:0];
            else win_len_reg = val;
        endfunction

        function void note_page(bit [15:0] page);
            lookup_result_t r;
            int unsigned n, act, slot, len;
            bit found;
            n = (frames_reg == 0) ? 1 :
                (frames_reg > lpft_pkg::MaxFrames ? lpft_pkg::MaxFrames : frames_reg);
            act = (filled < n) ? filled : n;
            found = 0; slot = 0;
            r = '0;
            r.window_number = cur_win[2:0];
            for (int i = 0; i < act; i++)
                if (!found && page_tbl[i] == page) begin found = 1; slot = i; end
            if (!found) begin
                if (filled < n) begin
                    slot = filled; filled++; act = filled;
                end
                else begin
                    slot = 0;
                    for (int i = 1; i < act; i++)
                        if (age_tbl[i] > age_tbl[slot]) slot = i;
                    r.evicted = 1;
                    r.evicted_page = page_tbl[slot];
                end
                page_tbl[slot] = page;
                if (cur_win < lpft_pkg::NumWindows && win_faults[cur_win] != 16'hFFFF)
                    win_faults[cur_win]++;
                if (fault_sum != 32'hFFFF_FFFF) fault_sum++;
            end
            for (int i = 0; i < act; i++)
                if (age_tbl[i] != {lpft_pkg::AgeBits{1'b1}}) age_tbl[i]++;
            age_tbl[slot] = '0;
            if (cur_win < lpft_pkg::NumWindows) begin
                r.window_faults = win_faults[cur_win];
                len = (win_len_reg == 0) ? 1 : win_len_reg;
                win_pos++;
                if (win_pos >= len) begin win_pos = 0; cur_win++; end
            end
            r.hit = found;
            r.frame_index = slot[6:0];
            r.total_faults = fault_sum;
            pending = {pending, r};
        endfunction

        function void check_beat(logic [79:0] d);
            lookup_result_t e, a;
            a.hit = d[0]; a.frame_index = d[7:1]; a.evicted = d[8];
            a.evicted_page = d[24:9]; a.window_number = d[27:25];
            a.window_faults = d[43:28]; a.total_faults = d[75:44];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", d);
                return;
            end
            e = pending.pop_front();
            if (e != a) begin
                errors++;
                if (errors <= 10) begin
                    $display("exp hit=%0d fi=%0d ev=%0d evp=%h win=%0d wf=%0d tot=%0d",
                        e.hit, e.frame_index, e.evicted, e.evicted_page,
                        e.window_number, e.window_faults, e.total_faults);
                    $display("got hit=%0d fi=%0d ev=%0d evp=%h win=%0d wf=%0d tot=%0d",
                        a.hit, a.frame_index, a.evicted, a.evicted_page,
                        a.window_number, a.window_faults, a.total_faults);
                end
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    logic        m_tuser;

    lru_scoreboard lru_sb;
    int unsigned hold_cycles = 0;
    bit          draining = 0;

    lru_page_frame_tracker i_dut (.*);

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic write_reg(logic idx, bit [15:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        lru_sb.set_reg(idx, val);
    endtask

    // offer one page, hold until taken; valid stays up if no gap follows
    task automatic send_page(bit [15:0] page, bit use_gaps);
        int unsigned gap;
        s_tvalid <= 1; s_tdata <= page;
        do @(posedge clk); while (!s_tready);
        lru_sb.note_page(page);
        gap = use_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic quiesce();
        s_tvalid <= 0;
        while (lru_sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // receiver: random stalls, and one long hold-off on request
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) lru_sb.check_beat(m_tdata);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end
        else if (draining) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 9) < 7);
    end

    initial begin
        #2_000_000;
        $display("lru_page_frame_tracker: mismatch");
        $finish;
    end

    initial begin
        bit [15:0] base;
        lru_sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: page extremes, fills, hits, evictions at two frames and at one frame
        write_reg(lpft_pkg::RegWindowLen, 16'd3);
        write_reg(lpft_pkg::RegFrameCount, 8'd2);
        send_page(16'h0000, 0); send_page(16'hFFFF, 0); send_page(16'h0000, 0);
        send_page(16'h5555, 0); send_page(16'hAAAA, 0); send_page(16'hAAAA, 0);
        quiesce();
        write_reg(lpft_pkg::RegFrameCount, 8'd0);
        send_page(16'h1234, 0); send_page(16'h1234, 0); send_page(16'h4321, 0);
        quiesce();
        // grow back: older frames come active again, duplicate pages possible
        write_reg(lpft_pkg::RegFrameCount, 8'd200);
        write_reg(lpft_pkg::RegWindowLen, 16'd0);
        send_page(16'h1234, 0); send_page(16'h5555, 0); send_page(16'h0000, 0);
        send_page(16'h7777, 0); send_page(16'h8888, 0);
        quiesce();
        write_reg(lpft_pkg::RegWindowLen, 16'hFFFF);

        // long receiver hold-off while sender keeps offering
        hold_cycles = 300;
        for (int i = 0; i < 20; i++) send_page($urandom_range(0, 15), 0);
        quiesce();

        // random phases: frame counts of 1, 128, 255 and small random ones; mostly localized page sets
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_reg(lpft_pkg::RegFrameCount, 8'd1);
                1: write_reg(lpft_pkg::RegFrameCount, 8'd128);
                2: write_reg(lpft_pkg::RegFrameCount, 8'd255);
                default: write_reg(lpft_pkg::RegFrameCount, 16'($urandom_range(1, 16)));
            endcase
            write_reg(lpft_pkg::RegWindowLen,
                      (ph == 7) ? 16'd2000 : 16'($urandom_range(1, 60)));
            base = $urandom;
            for (int i = 0; i < 200; i++) begin
                if ($urandom_range(0, 9) == 0) send_page($urandom, 1);
                else send_page(base + $urandom_range(0, 20), 1);
            end
            quiesce();
        end

        draining = 1;
        quiesce();
        if (lru_sb.errors == 0 && lru_sb.pending.size() == 0)
            $display("lru_page_frame_tracker: match");
        else
            $display("lru_page_frame_tracker: mismatch");
        $finish;
    end
endmodule

### lru_page_frame_tracker.f
rtl/lpft_pkg.sv
rtl/lpft_cell.sv
rtl/lru_page_frame_tracker.sv
tb/lru_page_frame_tracker_tb.sv
